// ===== rtl/tlbf_pkg.sv =====
// ----------------------------------------------------------------------------
// tlbf_pkg
// Shared types and constants for the FIFO-replacement TLB: default sizes,
// port field widths and the control word that the top level sends each cell.
// ----------------------------------------------------------------------------
package tlbf_pkg;

  // default table geometry
  localparam int TLB_ENTRIES_DEF = 16;
  localparam int PAGE_BITS_DEF   = 8;
  localparam int FRAME_BITS_DEF  = 8;

  // fixed port field widths
  localparam int PAGE_W  = 8;
  localparam int FRAME_W = 8;

  // operation codes carried in s_tuser
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  // per-cycle command to every cell
  typedef struct packed {
    logic upd;    // accepted update word, rewrite frame on own match
    logic shift;  // full table miss, take neighbor contents
    logic load;   // append slot select for this cell
  } cell_ctrl_t;

endpackage

// ===== rtl/tlbf_cell.sv =====
// ----------------------------------------------------------------------------
// tlbf_cell
// One TLB slot: holds a page/frame pair and its valid bit, compares the
// search key every cycle and hands its contents to the neighbor toward the
// head when the table shifts.
// ----------------------------------------------------------------------------
module tlbf_cell #(
  parameter int PAGE_BITS  = tlbf_pkg::PAGE_BITS_DEF,
  parameter int FRAME_BITS = tlbf_pkg::FRAME_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  tlbf_pkg::cell_ctrl_t   ctrl,
  input  logic [PAGE_BITS-1:0]   key_page,
  input  logic [FRAME_BITS-1:0]  new_frame,
  input  logic                   nbr_valid,
  input  logic [PAGE_BITS-1:0]   nbr_page,
  input  logic [FRAME_BITS-1:0]  nbr_frame,
  output logic                   valid,
  output logic [PAGE_BITS-1:0]   page,
  output logic [FRAME_BITS-1:0]  frame,
  output logic                   match
);
  import tlbf_pkg::*;

  // compare against the search key
  assign match = valid && (page == key_page);

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= nbr_valid;
    end else if (ctrl.load) begin
      valid <= 1'b1;
    end
  end

  // page and frame payload
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      page  <= nbr_page;
      frame <= nbr_frame;
    end else if (ctrl.load) begin
      page  <= key_page;
      frame <= new_frame;
    end else if (ctrl.upd && match) begin
      frame <= new_frame;
    end
  end

endmodule

// ===== rtl/tlb_fifo_lookup_update_top.sv =====
// ----------------------------------------------------------------------------
// tlb_fifo_lookup_update_top
// Fully associative TLB with FIFO replacement, built as a row of slot cells
// that all compare at once and shift toward the head on eviction.
//
//   channel | dir | tdata (low bit up)          | tuser
//   --------+-----+-----------------------------+---------------------------
//   s_*     | in  | page_number[7:0],           | operation (0 lookup,
//           |     | frame_number[15:8]          |   1 update)
//   m_*     | out | frame_found[7:0]            | hit
//
// One word is accepted per cycle while the output register is empty or being
// taken; its result appears in the output register on the next cycle. The
// compare across all cells plus the OR of the matching frame sets the critical
// path. s_tready is low in reset and while the output register is full and
// not taken. Reset clears all valid bits, the fill count and the output valid.
// ----------------------------------------------------------------------------
module tlb_fifo_lookup_update_top #(
  parameter int TLB_ENTRIES = tlbf_pkg::TLB_ENTRIES_DEF,
  parameter int PAGE_BITS   = tlbf_pkg::PAGE_BITS_DEF,
  parameter int FRAME_BITS  = tlbf_pkg::FRAME_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [tlbf_pkg::PAGE_W+tlbf_pkg::FRAME_W-1:0] s_tdata, // page_number, frame_number
  input  logic                                   s_tuser,  // operation
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [tlbf_pkg::FRAME_W-1:0]           m_tdata,  // frame_found
  output logic                                   m_tuser   // hit
);
  import tlbf_pkg::*;

  localparam int CNT_W = $clog2(TLB_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TLB_ENTRIES);

  logic                  in_fire;
  logic                  op_upd;
  logic [PAGE_BITS-1:0]  key_page;
  logic [FRAME_BITS-1:0] new_frame;
  logic [CNT_W-1:0]      filled_count;
  logic                  full;
  logic                  any_hit;
  logic                  ins_miss;
  logic [FRAME_BITS-1:0] hit_frame;

  logic [TLB_ENTRIES-1:0]                 cell_valid;
  logic [TLB_ENTRIES-1:0]                 cell_match;
  logic [TLB_ENTRIES-1:0][PAGE_BITS-1:0]  cell_page;
  logic [TLB_ENTRIES-1:0][FRAME_BITS-1:0] cell_frame;
  logic [TLB_ENTRIES-1:0]                 nbr_valid;
  logic [TLB_ENTRIES-1:0][PAGE_BITS-1:0]  nbr_page;
  logic [TLB_ENTRIES-1:0][FRAME_BITS-1:0] nbr_frame;
  cell_ctrl_t [TLB_ENTRIES-1:0]           cell_ctrl;

  // input handshake and field unpack
  assign s_tready  = !rst && (!m_tvalid || m_tready);
  assign in_fire   = s_tvalid && s_tready;
  assign op_upd    = (s_tuser == OP_UPDATE);
  assign key_page  = PAGE_BITS'(s_tdata[PAGE_W-1:0]);
  assign new_frame = FRAME_BITS'(s_tdata[PAGE_W+FRAME_W-1:PAGE_W]);

  // hit detect and frame select (pages are unique, so an OR picks the match)
  always_comb begin
    hit_frame = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      hit_frame = hit_frame | (cell_frame[i] & {FRAME_BITS{cell_match[i]}});
    end
  end
  assign any_hit  = |cell_match;
  assign full     = (filled_count == FULL_CNT);
  assign ins_miss = in_fire && op_upd && !any_hit;

  // cell row: each cell is fed by its neighbor toward the tail
  for (genvar g = 0; g < TLB_ENTRIES; g++) begin : g_cell
    if (g == TLB_ENTRIES - 1) begin : g_tail
      assign nbr_valid[g] = 1'b1;
      assign nbr_page[g]  = key_page;
      assign nbr_frame[g] = new_frame;
    end else begin : g_body
      assign nbr_valid[g] = cell_valid[g+1];
      assign nbr_page[g]  = cell_page[g+1];
      assign nbr_frame[g] = cell_frame[g+1];
    end

    assign cell_ctrl[g].upd   = in_fire && op_upd;
    assign cell_ctrl[g].shift = ins_miss && full;
    assign cell_ctrl[g].load  = ins_miss && !full && (filled_count == CNT_W'(g));

    tlbf_cell #(
      .PAGE_BITS  (PAGE_BITS),
      .FRAME_BITS (FRAME_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (cell_ctrl[g]),
      .key_page  (key_page),
      .new_frame (new_frame),
      .nbr_valid (nbr_valid[g]),
      .nbr_page  (nbr_page[g]),
      .nbr_frame (nbr_frame[g]),
      .valid     (cell_valid[g]),
      .page      (cell_page[g]),
      .frame     (cell_frame[g]),
      .match     (cell_match[g])
    );
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      filled_count <= '0;
    end else if (ins_miss && !full) begin
      filled_count <= filled_count + 1'b1;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      m_tuser <= any_hit;
      m_tdata <= (!op_upd && any_hit) ? FRAME_W'(hit_frame) : '0;
    end
  end

endmodule

// ===== rtl/tlbf_checker.sv =====
// ----------------------------------------------------------------------------
// tlbf_checker
// Port-level checks for the FIFO-replacement TLB, bound to the top level.
// ----------------------------------------------------------------------------
module tlbf_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [15:0] s_tdata,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        m_tuser
);
  import tlbf_pkg::*;

  // a stalled result stays presented
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // every accepted word yields a result next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted word produced no result");

  // a nonzero frame is only reported on a hit
  a_frame_hit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata != 8'd0) |-> m_tuser)
    else $error("frame reported without hit");

  // reset empties the output register
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // an update followed by a lookup of the same page hits with the new frame
  a_upd_lookup: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser == OP_UPDATE)) ##1
    (s_tvalid && s_tready && (s_tuser == OP_LOOKUP) &&
     (s_tdata[7:0] == $past(s_tdata[7:0])))
    |=> m_tuser && (m_tdata == $past(s_tdata[15:8], 2)))
    else $error("lookup after update missed or gave wrong frame");

endmodule

bind tlb_fifo_lookup_update_top tlbf_checker u_tlbf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
